// File: rtl/mlrc_pkg.sv
// Shared constants and types for the move-log retrace controller.
`default_nettype none

package mlrc_pkg;

    localparam int LOG_DEPTH  = 128;
    localparam int IDX_W      = $clog2(LOG_DEPTH);
    localparam int COUNT_W    = 16;
    localparam int WIDTH_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [WIDTH_W-1:0] WINDOW_LOW_RST  = 16'd12500;
    localparam logic [WIDTH_W-1:0] WINDOW_HIGH_RST = 16'd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LOW  = 1'b0,
        CFG_WINDOW_HIGH = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_HOLD    = 3'd0,
        CMD_STOP    = 3'd1,
        CMD_FORWARD = 3'd2,
        CMD_RIGHT   = 3'd3,
        CMD_BACK    = 3'd4,
        CMD_LEFT    = 3'd5
    } t_motor_cmd;

endpackage

`default_nettype wire

// File: rtl/move_log_retrace_controller.sv
// Top level of the move-log retrace controller: search, logging and replay in one pass.
`default_nettype none

// The block takes one request per clock cycle and gives one result per request in the
// cycle after it is taken. A new request can enter in the same cycle as the waiting result
// is taken; the input is stalled only while a result is held back by the output stall.
// The run log lives in a RAM of LOG_DEPTH entries with one write and one registered read
// a cycle; the entry under the cursor and the entry below it are kept in registers, so
// each request does one read-modify-write of the log. There is no clearing pass after
// reset: only entry 0 can be used before it is written, and a flag makes it read as zero
// until then. The window registers are to be written only while idle; it is not enforced.
module move_log_retrace_controller (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mlrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mlrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_valid,
    output      logic                                o_stall,
    input  wire logic                                i_kind,
    input  wire logic [mlrc_pkg::WIDTH_W-1:0]        i_ir_width,
    output      logic                                o_valid,
    input  wire logic                                i_stall,
    output      logic [2:0]                          o_motor_cmd,
    output      logic                                o_returning,
    output      logic                                o_log_full
);

    localparam logic [mlrc_pkg::IDX_W-1:0] LAST_IDX = mlrc_pkg::IDX_W'(mlrc_pkg::LOG_DEPTH - 1);
    localparam logic [mlrc_pkg::IDX_W-1:0] IDX_ONE  = mlrc_pkg::IDX_W'(1);
    localparam logic [mlrc_pkg::IDX_W-1:0] IDX_TWO  = mlrc_pkg::IDX_W'(2);
    localparam logic [mlrc_pkg::IDX_W-1:0] IDX_ZERO = '0;
    localparam logic [mlrc_pkg::COUNT_W-1:0] CNT_ONE = mlrc_pkg::COUNT_W'(1);

    // Configuration
    logic [mlrc_pkg::WIDTH_W-1:0] r_win_low;
    logic [mlrc_pkg::WIDTH_W-1:0] r_win_high;

    // Controller state
    logic [mlrc_pkg::IDX_W-1:0]   r_idx,  n_idx;
    logic [mlrc_pkg::COUNT_W-1:0] r_cur,  n_cur;
    logic                         r_turn, n_turn;
    logic                         r_ret,  n_ret;
    logic                         r_done, n_done;
    logic                         r_e0_valid;

    // Count of the entry below the cursor: either held or just read from the log
    logic [mlrc_pkg::COUNT_W-1:0] r_below;
    logic                         r_use_mem;
    logic                         r_mem_zero;
    logic [mlrc_pkg::COUNT_W-1:0] r_mem_q;
    logic [mlrc_pkg::COUNT_W-1:0] w_below;

    logic [mlrc_pkg::COUNT_W-1:0] r_log [mlrc_pkg::LOG_DEPTH];

    logic                         w_we;
    logic [mlrc_pkg::IDX_W-1:0]   w_waddr;
    logic [mlrc_pkg::COUNT_W-1:0] w_wdata;
    logic [mlrc_pkg::IDX_W-1:0]   w_raddr;
    logic                         w_move_up;
    logic                         w_move_down;

    logic                         w_accept;
    logic                         w_in_window;
    logic                         w_want_turn;
    logic [mlrc_pkg::COUNT_W-1:0] w_dec;

    mlrc_pkg::t_motor_cmd         n_cmd;
    logic                         n_full;

    // Output register
    logic                         r_out_valid;
    mlrc_pkg::t_motor_cmd         r_out_cmd;
    logic                         r_out_ret;
    logic                         r_out_full;

    assign o_stall     = r_out_valid & i_stall;
    assign w_accept    = i_valid & ~o_stall;
    assign o_valid     = r_out_valid;
    assign o_motor_cmd = r_out_cmd;
    assign o_returning = r_out_ret;
    assign o_log_full  = r_out_full;

    assign w_below     = r_use_mem ? (r_mem_zero ? '0 : r_mem_q) : r_below;
    assign w_in_window = (i_ir_width > r_win_low) && (i_ir_width < r_win_high);
    assign w_want_turn = ~w_in_window;
    assign w_dec       = r_cur - CNT_ONE;
    assign w_raddr     = r_idx - IDX_TWO;

    always_comb begin
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_turn      = r_turn;
        n_ret       = r_ret;
        n_done      = r_done;
        n_cmd       = mlrc_pkg::CMD_HOLD;
        n_full      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_cur;
        w_move_up   = 1'b0;
        w_move_down = 1'b0;

        if (i_kind) begin
            n_ret = 1'b1;
        end else if (r_ret) begin
            if (r_done) begin
                n_cmd = mlrc_pkg::CMD_STOP;
            end else if (r_cur == '0) begin
                if (r_idx == IDX_ZERO) begin
                    n_done = 1'b1;
                    n_cmd  = mlrc_pkg::CMD_STOP;
                end else begin
                    // An empty entry above the bottom is skipped with a hold.
                    w_move_down = 1'b1;
                end
            end else begin
                n_cmd   = r_turn ? mlrc_pkg::CMD_LEFT : mlrc_pkg::CMD_BACK;
                w_we    = 1'b1;
                w_wdata = w_dec;
                n_cur   = w_dec;
                if (w_dec == '0 && r_idx != IDX_ZERO) begin
                    w_move_down = 1'b1;
                end
            end
            if (w_move_down) begin
                n_idx  = r_idx - IDX_ONE;
                n_turn = ~r_turn;
                n_cur  = w_below;
            end
        end else begin
            n_cmd = w_want_turn ? mlrc_pkg::CMD_RIGHT : mlrc_pkg::CMD_FORWARD;
            if (w_want_turn != r_turn) begin
                if (r_idx != LAST_IDX) begin
                    w_move_up = 1'b1;
                    n_idx     = r_idx + IDX_ONE;
                    n_turn    = w_want_turn;
                    n_cur     = CNT_ONE;
                    w_we      = 1'b1;
                    w_waddr   = r_idx + IDX_ONE;
                    w_wdata   = CNT_ONE;
                end else begin
                    n_full = 1'b1;
                end
            end else if (r_cur != mlrc_pkg::COUNT_MAX) begin
                n_cur   = r_cur + CNT_ONE;
                w_we    = 1'b1;
                w_wdata = r_cur + CNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_low  <= mlrc_pkg::WINDOW_LOW_RST;
            r_win_high <= mlrc_pkg::WINDOW_HIGH_RST;
        end else if (i_cfg_we) begin
            case (mlrc_pkg::t_cfg_idx'(i_cfg_idx))
                mlrc_pkg::CFG_WINDOW_LOW:  r_win_low  <= i_cfg_data[mlrc_pkg::WIDTH_W-1:0];
                mlrc_pkg::CFG_WINDOW_HIGH: r_win_high <= i_cfg_data[mlrc_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_cur      <= '0;
            r_turn     <= 1'b1;
            r_ret      <= 1'b0;
            r_done     <= 1'b0;
            r_e0_valid <= 1'b0;
            r_use_mem  <= 1'b0;
        end else if (w_accept) begin
            r_idx  <= n_idx;
            r_cur  <= n_cur;
            r_turn <= n_turn;
            r_ret  <= n_ret;
            r_done <= n_done;
            if (w_we && w_waddr == IDX_ZERO) begin
                r_e0_valid <= 1'b1;
            end
            // After a step down the new lower neighbour comes from the log read below.
            r_use_mem <= w_move_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_move_up) begin
                r_below <= r_cur;
            end else if (!w_move_down) begin
                r_below <= w_below;
            end
            r_mem_zero <= (w_raddr == IDX_ZERO) && !r_e0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            r_log[w_waddr] <= w_wdata;
        end
        if (w_accept) begin
            r_mem_q <= r_log[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_cmd  <= n_cmd;
            r_out_ret  <= n_ret;
            r_out_full <= n_full;
        end
    end

endmodule

`default_nettype wire
